FILE: rtl/tps_pkg.sv
// Types, constants and the divider step shared by the triangle plane slicer.
package tps_pkg;

  localparam int NUM_LANES  = 4;
  localparam int QUO_BITS   = 34;
  localparam int PRE_STAGES = 5;
  localparam int NUM_STAGES = PRE_STAGES + QUO_BITS + 2;

  localparam logic       REG_PLANE_BASE      = 1'b0;
  localparam logic       REG_LAYER_THICKNESS = 1'b1;

  localparam logic [1:0] PAIR_01_02 = 2'd0;
  localparam logic [1:0] PAIR_01_12 = 2'd1;
  localparam logic [1:0] PAIR_02_12 = 2'd2;

  typedef struct packed {
    logic        hit;
    logic [1:0]  pair;
    logic [31:0] z;
    logic [15:0] tag;
    logic [11:0] layer;
  } com_t;

  typedef struct packed {
    logic [32:0]         rem;
    logic [QUO_BITS-1:0] nlo;
    logic [QUO_BITS-1:0] quo;
    logic [32:0]         d;
    logic                neg;
    logic                flat;
    logic [31:0]         ca;
  } div_t;

  function automatic div_t div_step(div_t x);
    div_t        y;
    logic [33:0] t;
    y = x;
    t = {x.rem, x.nlo[QUO_BITS-1]};
    y.nlo = {x.nlo[QUO_BITS-2:0], 1'b0};
    if (t >= {1'b0, x.d}) begin
      y.rem = 33'(t - {1'b0, x.d});
      y.quo = {x.quo[QUO_BITS-2:0], 1'b1};
    end else begin
      y.rem = t[32:0];
      y.quo = {x.quo[QUO_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

FILE: rtl/triangle_plane_slicer_core.sv
// Triangle plane slicer: pipelined edge crossing and interpolation.
// One result per item; throughput is one item per cycle while out_stall is low.
// A 34-stage restoring divider per lane sets the pipeline depth.
// Stall: each stage advances when it is empty or the next stage advances.
// Reset: synchronous, clears all valid bits; plane_base 0, layer_thickness 65536.
module triangle_plane_slicer_core import tps_pkg::*; #(
  parameter int MAX_LAYERS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] v0_x,
  input  logic signed [31:0] v0_y,
  input  logic signed [31:0] v0_z,
  input  logic signed [31:0] v1_x,
  input  logic signed [31:0] v1_y,
  input  logic signed [31:0] v1_z,
  input  logic signed [31:0] v2_x,
  input  logic signed [31:0] v2_y,
  input  logic signed [31:0] v2_z,
  input  logic [11:0]        layer_index,
  input  logic [15:0]        triangle_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] start_z,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  output logic signed [31:0] end_z,
  output logic [1:0]         edge_pair,
  output logic [15:0]        tag_out,
  output logic [11:0]        layer_out
);

  logic signed [31:0] plane_base;
  logic [30:0]        layer_thickness;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  logic signed [31:0] s0_v [9];
  logic [42:0]        s0_prod;
  logic [11:0]        s0_layer;
  logic [15:0]        s0_tag;

  logic signed [31:0] s1_v [9];
  logic signed [43:0] s1_h;
  logic               s1_ok;
  logic [11:0]        s1_layer;
  logic [15:0]        s1_tag;

  logic signed [31:0] s2_p [2][3];
  logic signed [31:0] s2_q [2][3];
  logic signed [43:0] s2_h;
  com_t               s2_com;

  logic [32:0] s3_mdh  [NUM_LANES];
  logic [32:0] s3_mdc  [NUM_LANES];
  logic [32:0] s3_d    [NUM_LANES];
  logic        s3_neg  [NUM_LANES];
  logic        s3_flat [NUM_LANES];
  logic [31:0] s3_ca   [NUM_LANES];
  com_t        s3_com;

  logic [49:0] s4_lo   [NUM_LANES];
  logic [48:0] s4_hi   [NUM_LANES];
  logic [32:0] s4_d    [NUM_LANES];
  logic        s4_neg  [NUM_LANES];
  logic        s4_flat [NUM_LANES];
  logic [31:0] s4_ca   [NUM_LANES];
  com_t        s4_com;

  div_t dv  [QUO_BITS+1][NUM_LANES];
  com_t dvc [QUO_BITS+1];

  logic signed [31:0] res [NUM_LANES];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_base      <= '0;
      layer_thickness <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_BASE:      plane_base      <= cfg_data;
        REG_LAYER_THICKNESS: layer_thickness <= cfg_data[30:0];
        default:             plane_base      <= plane_base;
      endcase
    end
  end

  // stage enables and valid bits
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // capture and layer product
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_v[0]  <= v0_x;  s0_v[1] <= v0_y;  s0_v[2] <= v0_z;
      s0_v[3]  <= v1_x;  s0_v[4] <= v1_y;  s0_v[5] <= v1_z;
      s0_v[6]  <= v2_x;  s0_v[7] <= v2_y;  s0_v[8] <= v2_z;
      s0_prod  <= 43'(layer_index) * 43'(layer_thickness);
      s0_layer <= layer_index;
      s0_tag   <= triangle_tag;
    end
  end

  // plane height
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_v     <= s0_v;
      s1_h     <= 44'(plane_base) + signed'({1'b0, s0_prod});
      s1_ok    <= 32'(s0_layer) < MAX_LAYERS;
      s1_layer <= s0_layer;
      s1_tag   <= s0_tag;
    end
  end

  // edge tests and pair selection
  logic        cr [3];
  logic        sel_hit;
  logic [1:0]  sel_pair;

  function automatic logic spans(logic signed [31:0] za, logic signed [31:0] zb,
                                 logic signed [43:0] h);
    logic signed [43:0] a;
    logic signed [43:0] b;
    a = 44'(za);
    b = 44'(zb);
    return ((a <= h) || (b <= h)) && ((a >= h) || (b >= h));
  endfunction

  always_comb begin
    cr[0] = spans(s1_v[2], s1_v[5], s1_h);
    cr[1] = spans(s1_v[2], s1_v[8], s1_h);
    cr[2] = spans(s1_v[5], s1_v[8], s1_h);
    sel_hit  = 1'b0;
    sel_pair = PAIR_01_02;
    priority if (!s1_ok) begin
      sel_hit = 1'b0;
    end else if (cr[0] && cr[1] && !cr[2]) begin
      sel_hit = 1'b1; sel_pair = PAIR_01_02;
    end else if (cr[0] && cr[2] && !cr[1]) begin
      sel_hit = 1'b1; sel_pair = PAIR_01_12;
    end else if (cr[1] && cr[2] && !cr[0]) begin
      sel_hit = 1'b1; sel_pair = PAIR_02_12;
    end else begin
      sel_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        unique case (sel_pair)
          PAIR_01_02: begin
            s2_p[0][c] <= s1_v[c];   s2_q[0][c] <= s1_v[3+c];
            s2_p[1][c] <= s1_v[c];   s2_q[1][c] <= s1_v[6+c];
          end
          PAIR_01_12: begin
            s2_p[0][c] <= s1_v[c];   s2_q[0][c] <= s1_v[3+c];
            s2_p[1][c] <= s1_v[3+c]; s2_q[1][c] <= s1_v[6+c];
          end
          default: begin
            s2_p[0][c] <= s1_v[c];   s2_q[0][c] <= s1_v[6+c];
            s2_p[1][c] <= s1_v[3+c]; s2_q[1][c] <= s1_v[6+c];
          end
        endcase
      end
      s2_h         <= s1_h;
      s2_com.hit   <= sel_hit;
      s2_com.pair  <= sel_hit ? sel_pair : PAIR_01_02;
      s2_com.z     <= sel_hit ? s1_h[31:0] : 32'd0;
      s2_com.tag   <= s1_tag;
      s2_com.layer <= s1_layer;
    end
  end

  // lane deltas and magnitudes
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        logic signed [32:0] dc;
        logic signed [32:0] dz;
        logic signed [43:0] dh;
        dc = 33'(s2_q[l/2][l%2]) - 33'(s2_p[l/2][l%2]);
        dz = 33'(s2_q[l/2][2]) - 33'(s2_p[l/2][2]);
        dh = s2_h - 44'(s2_p[l/2][2]);
        s3_neg[l]  <= dc[32];
        s3_mdc[l]  <= dc[32] ? 33'(-dc) : 33'(dc);
        s3_d[l]    <= dz[32] ? 33'(-dz) : 33'(dz);
        s3_mdh[l]  <= dh[43] ? 33'(-dh) : 33'(dh);
        s3_flat[l] <= (dz == '0);
        s3_ca[l]   <= s2_p[l/2][l%2];
      end
      s3_com <= s2_com;
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s4_lo[l]   <= 50'(s3_mdh[l]) * 50'(s3_mdc[l][16:0]);
        s4_hi[l]   <= 49'(s3_mdh[l]) * 49'(s3_mdc[l][32:17]);
        s4_d[l]    <= s3_d[l];
        s4_neg[l]  <= s3_neg[l];
        s4_flat[l] <= s3_flat[l];
        s4_ca[l]   <= s3_ca[l];
      end
      s4_com <= s3_com;
    end
  end

  // rounded dividend, divider entry
  always_ff @(posedge clk) begin
    if (en[PRE_STAGES]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        logic [65:0] num;
        num = 66'(s4_lo[l]) + (66'(s4_hi[l]) << 17) + 66'(s4_d[l] >> 1);
        dv[0][l].rem  <= {1'b0, num[65:QUO_BITS]};
        dv[0][l].nlo  <= num[QUO_BITS-1:0];
        dv[0][l].quo  <= '0;
        dv[0][l].d    <= s4_d[l];
        dv[0][l].neg  <= s4_neg[l];
        dv[0][l].flat <= s4_flat[l];
        dv[0][l].ca   <= s4_ca[l];
      end
      dvc[0] <= s4_com;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[PRE_STAGES+k]) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          dv[k][l] <= div_step(dv[k-1][l]);
        end
        dvc[k] <= dvc[k-1];
      end
    end
  end

  // apply sign, flat edge and miss
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (!dvc[QUO_BITS].hit) begin
        res[l] = '0;
      end else if (dv[QUO_BITS][l].flat) begin
        res[l] = dv[QUO_BITS][l].ca;
      end else if (dv[QUO_BITS][l].neg) begin
        res[l] = 32'(34'(dv[QUO_BITS][l].ca) - dv[QUO_BITS][l].quo);
      end else begin
        res[l] = 32'(34'(dv[QUO_BITS][l].ca) + dv[QUO_BITS][l].quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      hit       <= dvc[QUO_BITS].hit;
      start_x   <= res[0];
      start_y   <= res[1];
      start_z   <= dvc[QUO_BITS].z;
      end_x     <= res[2];
      end_y     <= res[3];
      end_z     <= dvc[QUO_BITS].z;
      edge_pair <= dvc[QUO_BITS].pair;
      tag_out   <= dvc[QUO_BITS].tag;
      layer_out <= dvc[QUO_BITS].layer;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item not captured");

  a_pair_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> edge_pair != 2'd3)
    else $error("bad edge pair code");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> start_x == '0 && end_y == '0 && edge_pair == PAIR_01_02)
    else $error("miss result not cleared");

  a_same_z: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> start_z == end_z)
    else $error("segment ends at different heights");

endmodule
